FILE: rtl/lap_pkg.sv
// Shared types, sizes and helper functions for the lattice A* planner.
// Used by lap_isqrt and lattice_astar_planner; depends on nothing else.
package lap_pkg;

	// Grid and heap dimensions
	localparam int GRID_X     = 64;
	localparam int GRID_Y     = 32;
	localparam int HEADINGS   = 16;
	localparam int HEAP_DEPTH = 65536;

	localparam int XW     = $clog2(GRID_X);
	localparam int YW     = $clog2(GRID_Y);
	localparam int KW     = $clog2(HEADINGS);
	localparam int CELL_W = XW + YW;
	localparam int SIDX_W = CELL_W + KW;
	localparam int HAW    = $clog2(HEAP_DEPTH);
	localparam int HCNT_W = HAW + 1;

	// Costs, heuristic and keys
	localparam int COST_W = 16;
	localparam int H_W    = 15;
	localparam int KEY_W  = COST_W + 9;
	localparam int SEQ_W  = 24;
	localparam int EXP_W  = 16;

	// Square root unit: radicand holds (dx^2+dy^2) << 16
	localparam int RAD_W     = 30;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int ISQ_STEPS = RAD_W / 2;
	localparam int ISQ_CW    = $clog2(ISQ_STEPS);

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	// Item modes
	localparam logic MODE_OCC    = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [5:0] cell_x;
		logic [4:0] cell_y;
		logic       occupied;
		logic [5:0] start_x;
		logic [4:0] start_y;
		logic [3:0] start_heading;
		logic [5:0] goal_x;
		logic [4:0] goal_y;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [14:0] path_cost;
		logic [3:0]  end_heading;
		logic [15:0] expansions;
		logic        heap_overflow;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SEQ_W-1:0]  seq;
		logic [SIDX_W-1:0] idx;
	} heap_ent_t;

	typedef struct packed {
		logic              seen;
		logic              closed;
		logic [COST_W-1:0] cost;
	} st_ent_t;

	typedef enum logic [4:0] {
		S_OCC_CLR,
		S_IDLE,
		S_ST_CLR,
		S_START,
		S_START_HW,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_POP_CHK,
		S_POP_LD,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_SIFT_END,
		S_CUR_CHK,
		S_OCC_RD,
		S_OCC_CHK,
		S_HEUR_W,
		S_NB_RD,
		S_NB_CHK,
		S_DONE
	} state_t;

	// Cell step of a heading, x part
	function automatic logic signed [1:0] off_dx(input logic [KW-1:0] k);
		int sect;
		sect = (int'(k) * 16) / HEADINGS;
		case (sect)
			0, 1, 2, 14, 15:       off_dx = 2'sd1;
			3, 4, 5, 11, 12, 13:   off_dx = 2'sd0;
			default:               off_dx = -2'sd1;
		endcase
	endfunction

	// Cell step of a heading, y part
	function automatic logic signed [1:0] off_dy(input logic [KW-1:0] k);
		int sect;
		sect = (int'(k) * 16) / HEADINGS;
		case (sect)
			2, 3, 4, 5, 6:         off_dy = 2'sd1;
			10, 11, 12, 13, 14:    off_dy = -2'sd1;
			default:               off_dy = 2'sd0;
		endcase
	endfunction

	// Heap order: smaller key first, ties by push order
	function automatic logic ent_less(input heap_ent_t a, input heap_ent_t b);
		ent_less = (a.key < b.key) || ((a.key == b.key) && (a.seq < b.seq));
	endfunction

	// Radicand for the distance heuristic
	function automatic logic [RAD_W-1:0] heur_rad(input logic [XW-1:0] x,
		input logic [YW-1:0] y, input logic [XW-1:0] gx, input logic [YW-1:0] gy);
		logic [XW-1:0]     dx;
		logic [YW-1:0]     dy;
		logic [2*XW:0]     sum;
		dx  = (x > gx) ? (x - gx) : (gx - x);
		dy  = (y > gy) ? (y - gy) : (gy - y);
		sum = (2*XW+1)'(dx * dx) + (2*XW+1)'(dy * dy);
		heur_rad = RAD_W'({sum, 16'd0});
	endfunction

endpackage

FILE: rtl/lap_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
// Depends on lap_pkg for widths.
module lap_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lap_pkg::RAD_W-1:0]  radicand,
	output logic                       done,
	output logic [lap_pkg::ROOT_W-1:0] root
);

	logic [lap_pkg::RAD_W-1:0]  rad_q;
	logic [lap_pkg::ROOT_W+3:0] rem_q;
	logic [lap_pkg::ROOT_W-1:0] root_q;
	logic [lap_pkg::ISQ_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lap_pkg::ROOT_W+3:0] rem_sh;
	logic [lap_pkg::ROOT_W+3:0] trial;

	// Next remainder window and trial subtrahend
	assign rem_sh = {rem_q[lap_pkg::ROOT_W+1:0], rad_q[lap_pkg::RAD_W-1 -: 2]};
	assign trial  = (lap_pkg::ROOT_W+4)'({root_q, 2'b01});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == lap_pkg::ISQ_CW'(lap_pkg::ISQ_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[lap_pkg::RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[lap_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[lap_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/lattice_astar_planner.sv
// A* planner over a (column, row, heading) lattice: top level.
// Depends on lap_pkg and lap_isqrt.
//
// A mode 0 beat writes one occupancy cell. A mode 1 beat runs a search: a sweep
// clears all 32768 entries of the cost/closed store, then each expansion pops the
// open heap, reads the state store, runs the square root for the neighbor cell
// once, and pushes up to three neighbors. The length of a search is set by the
// number of expansions and the heap depth.
// After reset a sweep clears the 2048-cell occupancy store; no beat is taken then.
// The result sits in an output register, so the next beat is taken while it waits.
module lattice_astar_planner (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lap_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lap_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	localparam int NSTATES = 1 << lap_pkg::SIDX_W;
	localparam int NCELLS  = 1 << lap_pkg::CELL_W;
	localparam int NW      = lap_pkg::XW + 2;
	localparam int MW      = lap_pkg::YW + 2;

	// Memories
	logic                 occ_mem  [NCELLS];
	lap_pkg::st_ent_t     st_mem   [NSTATES];
	lap_pkg::heap_ent_t   heap_mem [lap_pkg::HEAP_DEPTH];

	// State and registers
	lap_pkg::state_t             state_q, state_d;
	logic [lap_pkg::CELL_W-1:0]  occ_addr_q;
	logic [lap_pkg::SIDX_W-1:0]  st_addr_q;
	logic [6:0]                  width_q;
	logic [5:0]                  height_q;
	logic [lap_pkg::XW-1:0]      sx_q, gx_q;
	logic [lap_pkg::YW-1:0]      sy_q, gy_q;
	logic [lap_pkg::KW-1:0]      sk_q;
	logic [lap_pkg::HCNT_W-1:0]  count_q;
	logic [lap_pkg::SEQ_W-1:0]   seq_q;
	logic [lap_pkg::HAW-1:0]     i_q;
	lap_pkg::heap_ent_t          e_q, top_q, last_q;
	logic [lap_pkg::COST_W-1:0]  cur_cost_q, cost_q;
	logic [lap_pkg::EXP_W-1:0]   expans_q;
	logic                        ovf_q, found_q;
	logic [lap_pkg::KW-1:0]      endh_q;
	logic signed [NW-1:0]        nx_q;
	logic signed [MW-1:0]        ny_q;
	logic [lap_pkg::H_W-1:0]     h_q;
	logic [1:0]                  p_q;
	logic                        ret_start_q;
	logic                        rsp_valid_q;
	lap_pkg::rsp_t               rsp_q;

	// Memory ports
	logic                        occ_we, occ_wd, occ_re, occ_rd;
	logic [lap_pkg::CELL_W-1:0]  occ_wa, occ_ra;
	logic                        st_we, st_re;
	logic [lap_pkg::SIDX_W-1:0]  st_wa, st_ra;
	lap_pkg::st_ent_t            st_wd, st_rd;
	logic                        h_we, h_re;
	logic [lap_pkg::HAW-1:0]     h_wa, h_ra0, h_ra1;
	lap_pkg::heap_ent_t          h_wd, hrd0, hrd1;

	// Square root unit
	logic                        isq_start, isq_done;
	logic [lap_pkg::RAD_W-1:0]   isq_rad;
	logic [lap_pkg::ROOT_W-1:0]  isq_root;

	// Derived values
	logic                        req_acc;
	logic [lap_pkg::KW-1:0]      cur_k, nk;
	logic [lap_pkg::XW-1:0]      cur_x;
	logic [lap_pkg::YW-1:0]      cur_y;
	logic [lap_pkg::SIDX_W-1:0]  si, ni;
	logic [lap_pkg::HAW-1:0]     parent;
	logic [lap_pkg::HCNT_W:0]    c_idx, c_plus, cnt_ext;
	logic                        use_c1;
	lap_pkg::heap_ent_t          child;
	logic [lap_pkg::HCNT_W:0]    c_sel;
	logic                        nb_in;
	logic [lap_pkg::COST_W-1:0]  ng;
	logic                        need_push, heap_full;
	logic                        push_fin;
	logic                        rsp_load;

	lap_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (isq_start),
		.radicand (isq_rad),
		.done     (isq_done),
		.root     (isq_root)
	);

	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// Popped state fields and neighbor index
	assign cur_k = top_q.idx[lap_pkg::KW-1:0];
	assign cur_x = top_q.idx[lap_pkg::KW +: lap_pkg::XW];
	assign cur_y = top_q.idx[lap_pkg::KW + lap_pkg::XW +: lap_pkg::YW];
	assign si    = {sy_q, sx_q, sk_q};

	always_comb begin
		nk = cur_k;
		case (p_q)
			2'd0: nk = (cur_k == '0) ? lap_pkg::KW'(lap_pkg::HEADINGS - 1) : cur_k - 1'b1;
			2'd2: nk = (cur_k == lap_pkg::KW'(lap_pkg::HEADINGS - 1)) ? '0 : cur_k + 1'b1;
			default: nk = cur_k;
		endcase
	end

	assign ni = {ny_q[lap_pkg::YW-1:0], nx_q[lap_pkg::XW-1:0], nk};

	// Bounds of the neighbor cell
	assign nb_in = !nx_q[NW-1] && !ny_q[MW-1]
		&& (9'(nx_q) < 9'(lap_pkg::GRID_X)) && (9'(nx_q) < 9'(width_q))
		&& (9'(ny_q) < 9'(lap_pkg::GRID_Y)) && (9'(ny_q) < 9'(height_q));

	// Heap index arithmetic
	assign parent  = (i_q - 1'b1) >> 1;
	assign c_idx   = {1'b0, i_q, 1'b1};
	assign c_plus  = c_idx + 1'b1;
	assign cnt_ext = {1'b0, count_q};
	assign use_c1  = (c_plus < cnt_ext) && lap_pkg::ent_less(hrd1, hrd0);
	assign child   = use_c1 ? hrd1 : hrd0;
	assign c_sel   = use_c1 ? c_plus : c_idx;

	// Relaxation of a neighbor
	assign ng        = cur_cost_q + 1'b1;
	assign need_push = !st_rd.seen || (ng < st_rd.cost);
	assign heap_full = count_q >= lap_pkg::HCNT_W'(lap_pkg::HEAP_DEPTH);

	// Push ends this cycle
	assign push_fin = ((state_q == lap_pkg::S_PUSH_RD) && (i_q == '0))
		|| ((state_q == lap_pkg::S_PUSH_CMP) && !lap_pkg::ent_less(e_q, hrd0));

	assign rsp_load = (state_q == lap_pkg::S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lap_pkg::S_OCC_CLR:
				if (occ_addr_q == '1) state_d = lap_pkg::S_IDLE;
			lap_pkg::S_IDLE:
				if (req_acc && (req.mode == lap_pkg::MODE_SEARCH)) state_d = lap_pkg::S_ST_CLR;
			lap_pkg::S_ST_CLR:
				if (st_addr_q == '1) state_d = lap_pkg::S_START;
			lap_pkg::S_START:
				state_d = lap_pkg::S_START_HW;
			lap_pkg::S_START_HW:
				if (isq_done) state_d = lap_pkg::S_PUSH_RD;
			lap_pkg::S_PUSH_RD, lap_pkg::S_PUSH_CMP: begin
				if (push_fin) begin
					if (ret_start_q || (p_q == 2'd2)) state_d = lap_pkg::S_POP_CHK;
					else state_d = lap_pkg::S_NB_RD;
				end else if (state_q == lap_pkg::S_PUSH_RD) begin
					state_d = lap_pkg::S_PUSH_CMP;
				end else begin
					state_d = lap_pkg::S_PUSH_RD;
				end
			end
			lap_pkg::S_POP_CHK:
				state_d = (count_q == '0) ? lap_pkg::S_DONE : lap_pkg::S_POP_LD;
			lap_pkg::S_POP_LD:
				state_d = lap_pkg::S_SIFT_RD;
			lap_pkg::S_SIFT_RD:
				state_d = (c_idx >= cnt_ext) ? lap_pkg::S_SIFT_END : lap_pkg::S_SIFT_CMP;
			lap_pkg::S_SIFT_CMP:
				state_d = lap_pkg::ent_less(child, last_q) ? lap_pkg::S_SIFT_RD
					: lap_pkg::S_SIFT_END;
			lap_pkg::S_SIFT_END:
				state_d = lap_pkg::S_CUR_CHK;
			lap_pkg::S_CUR_CHK: begin
				if (st_rd.closed) state_d = lap_pkg::S_POP_CHK;
				else if ((cur_x == gx_q) && (cur_y == gy_q)) state_d = lap_pkg::S_DONE;
				else state_d = lap_pkg::S_OCC_RD;
			end
			lap_pkg::S_OCC_RD:
				state_d = nb_in ? lap_pkg::S_OCC_CHK : lap_pkg::S_POP_CHK;
			lap_pkg::S_OCC_CHK:
				state_d = occ_rd ? lap_pkg::S_POP_CHK : lap_pkg::S_HEUR_W;
			lap_pkg::S_HEUR_W:
				if (isq_done) state_d = lap_pkg::S_NB_RD;
			lap_pkg::S_NB_RD:
				state_d = lap_pkg::S_NB_CHK;
			lap_pkg::S_NB_CHK: begin
				if (need_push) state_d = heap_full ? lap_pkg::S_DONE : lap_pkg::S_PUSH_RD;
				else if (p_q == 2'd2) state_d = lap_pkg::S_POP_CHK;
				else state_d = lap_pkg::S_NB_RD;
			end
			lap_pkg::S_DONE:
				if (rsp_load) state_d = lap_pkg::S_IDLE;
			default:
				state_d = lap_pkg::S_IDLE;
		endcase
	end

	// Memory and unit controls
	always_comb begin
		req_stall = (state_q != lap_pkg::S_IDLE);
		occ_we = 1'b0; occ_wa = occ_addr_q; occ_wd = 1'b0;
		occ_re = 1'b0; occ_ra = {ny_q[lap_pkg::YW-1:0], nx_q[lap_pkg::XW-1:0]};
		st_we = 1'b0;  st_wa = st_addr_q;   st_wd = '0;
		st_re = 1'b0;  st_ra = top_q.idx;
		h_we = 1'b0;   h_wa = i_q;          h_wd = e_q;
		h_re = 1'b0;   h_ra0 = parent;      h_ra1 = '0;
		isq_start = 1'b0;
		isq_rad = lap_pkg::heur_rad(nx_q[lap_pkg::XW-1:0], ny_q[lap_pkg::YW-1:0], gx_q, gy_q);
		case (state_q)
			lap_pkg::S_OCC_CLR:
				occ_we = 1'b1;
			lap_pkg::S_IDLE:
				if (req_acc && (req.mode == lap_pkg::MODE_OCC)) begin
					occ_we = 1'b1;
					occ_wa = {req.cell_y, req.cell_x};
					occ_wd = req.occupied;
				end
			lap_pkg::S_ST_CLR:
				st_we = 1'b1;
			lap_pkg::S_START: begin
				st_we     = 1'b1;
				st_wa     = si;
				st_wd     = '{seen: 1'b1, closed: 1'b0, cost: '0};
				isq_start = 1'b1;
				isq_rad   = lap_pkg::heur_rad(sx_q, sy_q, gx_q, gy_q);
			end
			lap_pkg::S_PUSH_RD:
				if (i_q == '0) h_we = 1'b1;
				else h_re = 1'b1;
			lap_pkg::S_PUSH_CMP: begin
				h_we = 1'b1;
				if (lap_pkg::ent_less(e_q, hrd0)) h_wd = hrd0;
			end
			lap_pkg::S_POP_CHK: begin
				h_re  = 1'b1;
				h_ra0 = '0;
				h_ra1 = lap_pkg::HAW'(count_q - 1'b1);
			end
			lap_pkg::S_SIFT_RD: begin
				h_re  = 1'b1;
				h_ra0 = lap_pkg::HAW'(c_idx);
				h_ra1 = lap_pkg::HAW'(c_plus);
			end
			lap_pkg::S_SIFT_CMP:
				if (lap_pkg::ent_less(child, last_q)) begin
					h_we = 1'b1;
					h_wd = child;
				end
			lap_pkg::S_SIFT_END: begin
				st_re = 1'b1;
				if (count_q != '0) begin
					h_we = 1'b1;
					h_wd = last_q;
				end
			end
			lap_pkg::S_CUR_CHK:
				if (!st_rd.closed) begin
					st_we = 1'b1;
					st_wa = top_q.idx;
					st_wd = '{seen: st_rd.seen, closed: 1'b1, cost: st_rd.cost};
				end
			lap_pkg::S_OCC_RD:
				occ_re = nb_in;
			lap_pkg::S_OCC_CHK:
				isq_start = !occ_rd;
			lap_pkg::S_NB_RD: begin
				st_re = 1'b1;
				st_ra = ni;
			end
			lap_pkg::S_NB_CHK:
				if (need_push && !heap_full) begin
					st_we = 1'b1;
					st_wa = ni;
					st_wd = '{seen: 1'b1, closed: st_rd.closed, cost: ng};
				end
			default: ;
		endcase
	end

	// Occupancy store
	always_ff @(posedge clk) begin
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		if (occ_re) occ_rd <= occ_mem[occ_ra];
	end

	// Cost and closed store
	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		if (st_re) st_rd <= st_mem[st_ra];
	end

	// Open heap
	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		if (h_re) begin
			hrd0 <= heap_mem[h_ra0];
			hrd1 <= heap_mem[h_ra1];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lap_pkg::S_OCC_CLR;
			occ_addr_q  <= '0;
			width_q     <= 7'd50;
			height_q    <= 6'd30;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lap_pkg::S_OCC_CLR) occ_addr_q <= occ_addr_q + 1'b1;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lap_pkg::CFG_WIDTH:  width_q  <= cfg_data[6:0];
					lap_pkg::CFG_HEIGHT: height_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lap_pkg::S_IDLE:
				if (req_acc && (req.mode == lap_pkg::MODE_SEARCH)) begin
					sx_q      <= req.start_x;
					sy_q      <= req.start_y;
					sk_q      <= lap_pkg::KW'(32'(req.start_heading) % lap_pkg::HEADINGS);
					gx_q      <= req.goal_x;
					gy_q      <= req.goal_y;
					st_addr_q <= '0;
					count_q   <= '0;
					seq_q     <= '0;
					expans_q  <= '0;
					ovf_q     <= 1'b0;
					found_q   <= 1'b0;
					cost_q    <= '0;
					endh_q    <= '0;
				end
			lap_pkg::S_ST_CLR:
				st_addr_q <= st_addr_q + 1'b1;
			lap_pkg::S_START_HW:
				if (isq_done) begin
					e_q         <= '{key: lap_pkg::KEY_W'(isq_root), seq: seq_q, idx: si};
					seq_q       <= seq_q + 1'b1;
					count_q     <= count_q + 1'b1;
					i_q         <= '0;
					ret_start_q <= 1'b1;
				end
			lap_pkg::S_PUSH_RD:
				if (push_fin && !ret_start_q && (p_q != 2'd2)) p_q <= p_q + 1'b1;
			lap_pkg::S_PUSH_CMP:
				if (!push_fin) i_q <= parent;
				else if (!ret_start_q && (p_q != 2'd2)) p_q <= p_q + 1'b1;
			lap_pkg::S_POP_LD: begin
				top_q   <= hrd0;
				last_q  <= hrd1;
				count_q <= count_q - 1'b1;
				i_q     <= '0;
			end
			lap_pkg::S_SIFT_CMP:
				if (lap_pkg::ent_less(child, last_q)) i_q <= lap_pkg::HAW'(c_sel);
			lap_pkg::S_CUR_CHK:
				if (!st_rd.closed) begin
					expans_q   <= expans_q + 1'b1;
					cur_cost_q <= st_rd.cost;
					nx_q       <= NW'(cur_x) + NW'(lap_pkg::off_dx(cur_k));
					ny_q       <= MW'(cur_y) + MW'(lap_pkg::off_dy(cur_k));
					if ((cur_x == gx_q) && (cur_y == gy_q)) begin
						found_q <= 1'b1;
						cost_q  <= st_rd.cost;
						endh_q  <= cur_k;
					end
				end
			lap_pkg::S_OCC_CHK:
				p_q <= 2'd0;
			lap_pkg::S_HEUR_W:
				if (isq_done) h_q <= lap_pkg::H_W'(isq_root);
			lap_pkg::S_NB_CHK:
				if (need_push) begin
					if (heap_full) begin
						ovf_q <= 1'b1;
					end else begin
						e_q <= '{key: lap_pkg::KEY_W'({ng, 8'd0}) + lap_pkg::KEY_W'(h_q),
							seq: seq_q, idx: ni};
						seq_q       <= seq_q + 1'b1;
						i_q         <= lap_pkg::HAW'(count_q);
						count_q     <= count_q + 1'b1;
						ret_start_q <= 1'b0;
					end
				end else if (p_q != 2'd2) begin
					p_q <= p_q + 1'b1;
				end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.found         <= found_q;
			rsp_q.path_cost     <= cost_q[14:0];
			rsp_q.end_heading   <= endh_q;
			rsp_q.expansions    <= expans_q;
			rsp_q.heap_overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: tb/lattice_astar_planner_tb.sv
// Self-checking testbench for lattice_astar_planner: occupancy writes and A* searches.
// Depends on lap_pkg and the planner RTL; holds its own search predictor.
`timescale 1ns / 100ps

module lattice_astar_planner_tb;
	import lap_pkg::*;

	localparam int QUIET_LIMIT = 2000000;

	// Search predictor and the queue of results it expects
	class search_scoreboard;
		bit              occ [GRID_X*GRID_Y];
		int unsigned     g_cost [GRID_X*GRID_Y*HEADINGS];
		bit              seen_st [GRID_X*GRID_Y*HEADINGS];
		bit              closed_st [GRID_X*GRID_Y*HEADINGS];
		longint unsigned open_key [$];
		int unsigned     open_seq [$];
		int unsigned     open_idx [$];
		int unsigned     cols;
		int unsigned     rows;
		rsp_t            expected_rsp [$];
		int              errors;
		int              searches;
		int              writes;

		function new();
			cols = 50;
			rows = 30;
		endfunction

		function void set_cfg(logic [1:0] index, logic [7:0] data);
			if (index == CFG_WIDTH)
				cols = data & 8'h7f;
			else if (index == CFG_HEIGHT)
				rows = data & 8'h3f;
		endfunction

		function longint unsigned dist_h(int x, int y, int gx, int gy);
			longint unsigned dx, dy, v, r;
			dx = (x > gx) ? x - gx : gx - x;
			dy = (y > gy) ? y - gy : gy - y;
			v = (dx*dx + dy*dy) << 16;
			r = longint'($sqrt(real'(v)));
			while (r*r > v) r--;
			while ((r+1)*(r+1) <= v) r++;
			return r;
		endfunction

		function bit free_cell(int x, int y);
			if (x < 0 || y < 0 || x >= GRID_X || y >= GRID_Y) return 0;
			if (x >= cols || y >= rows) return 0;
			return occ[y*GRID_X + x] == 0;
		endfunction

		function int step_dx(int k);
			int tbl [16] = '{1, 1, 1, 0, 0, 0, -1, -1, -1, -1, -1, 0, 0, 0, 1, 1};
			return tbl[k];
		endfunction

		function int step_dy(int k);
			int tbl [16] = '{0, 0, 1, 1, 1, 1, 1, 0, 0, 0, -1, -1, -1, -1, -1, 0};
			return tbl[k];
		endfunction

		// Accepted input beat: update occupancy or predict a search result
		function void note(req_t r);
			rsp_t e;
			int seq, sx, sy, gx, gy, ck, cx, cy, nx, ny, nk, p, best, ci, ni;
			int unsigned ng;
			if (r.mode != MODE_SEARCH) begin
				occ[int'(r.cell_y)*GRID_X + int'(r.cell_x)] = r.occupied;
				writes++;
				return;
			end
			searches++;
			e = '0;
			sx = r.start_x; sy = r.start_y; gx = r.goal_x; gy = r.goal_y;
			foreach (g_cost[i]) begin
				g_cost[i] = 0; seen_st[i] = 0; closed_st[i] = 0;
			end
			open_key.delete(); open_seq.delete(); open_idx.delete();
			seq = 0;
			ci = (sy*GRID_X + sx)*HEADINGS + int'(r.start_heading);
			seen_st[ci] = 1;
			open_key.push_back(dist_h(sx, sy, gx, gy)); open_seq.push_back(seq++);
			open_idx.push_back(ci);
			while (open_key.size() > 0 && !e.heap_overflow) begin
				best = 0;
				foreach (open_key[i])
					if (open_key[i] < open_key[best] ||
					    (open_key[i] == open_key[best] && open_seq[i] < open_seq[best]))
						best = i;
				ci = open_idx[best];
				open_key.delete(best); open_seq.delete(best); open_idx.delete(best);
				if (closed_st[ci]) continue;
				closed_st[ci] = 1;
				e.expansions++;
				ck = ci % HEADINGS;
				cx = (ci / HEADINGS) % GRID_X;
				cy = (ci / HEADINGS) / GRID_X;
				if (cx == gx && cy == gy) begin
					e.found = 1;
					e.path_cost = g_cost[ci];
					e.end_heading = ck;
					break;
				end
				// right arc, straight, left arc: same cell step for this geometry
				for (p = -1; p <= 1; p++) begin
					nx = cx + step_dx(ck);
					ny = cy + step_dy(ck);
					nk = (ck + p + HEADINGS) % HEADINGS;
					if (!free_cell(nx, ny)) continue;
					ni = (ny*GRID_X + nx)*HEADINGS + nk;
					ng = g_cost[ci] + 1;
					if (!seen_st[ni] || ng < g_cost[ni]) begin
						if (open_key.size() >= HEAP_DEPTH) begin
							e.heap_overflow = 1;
							break;
						end
						seen_st[ni] = 1;
						g_cost[ni] = ng;
						open_key.push_back((longint'(ng) << 8) + dist_h(nx, ny, gx, gy));
						open_seq.push_back(seq++);
						open_idx.push_back(ni);
					end
				end
			end
			if (e.heap_overflow) begin
				e.found = 0; e.path_cost = 0; e.end_heading = 0;
			end
			expected_rsp.push_back(e);
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		// Accepted result beat: compare with the oldest prediction
		task check(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report("unexpected result beat", 1, 0);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.found !== want.found) report("found", got.found, want.found);
			if (got.path_cost !== want.path_cost)
				report("path_cost", got.path_cost, want.path_cost);
			if (got.end_heading !== want.end_heading)
				report("end_heading", got.end_heading, want.end_heading);
			if (got.expansions !== want.expansions)
				report("expansions", got.expansions, want.expansions);
			if (got.heap_overflow !== want.heap_overflow)
				report("heap_overflow", got.heap_overflow, want.heap_overflow);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	search_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	lattice_astar_planner dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Result side: random stall, check each accepted beat
	initial begin
		rsp_stall = 0;
		forever begin
			@(negedge clk);
			rsp_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall) sb.check(rsp);

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// One request beat with optional leading idle cycles; entered and left at negedge
	task send(req_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid = 0;
			@(negedge clk);
		end
		req_valid = 1;
		req = item;
		do @(posedge clk); while (req_stall);
		sb.note(item);
		@(negedge clk);
	endtask

	task write_cfg(logic [1:0] index, logic [7:0] data);
		cfg_valid = 1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_cfg(index, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Pause the sender until all results are in, then let the block settle
	task drain();
		req_valid = 0;
		while (sb.expected_rsp.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task set_area(int w, int h);
		drain();
		write_cfg(CFG_WIDTH, w);
		write_cfg(CFG_HEIGHT, h);
	endtask

	function req_t occ_item(int x, int y, bit v);
		req_t r;
		r = {$urandom, $urandom};
		r.mode = MODE_OCC;
		r.cell_x = x; r.cell_y = y; r.occupied = v;
		return r;
	endfunction

	function req_t search_item(int sx, int sy, int k, int gx, int gy);
		req_t r;
		r = {$urandom, $urandom};
		r.mode = MODE_SEARCH;
		r.start_x = sx; r.start_y = sy; r.start_heading = k;
		r.goal_x = gx; r.goal_y = gy;
		return r;
	endfunction

	// Random beat: mostly inside the active area, sometimes anywhere
	function req_t random_item();
		req_t r;
		r = {$urandom, $urandom};
		if ($urandom_range(99) < 40) begin
			r.mode = MODE_OCC;
			if ($urandom_range(1)) begin
				r.cell_x = $urandom_range(sb.cols - 1);
				r.cell_y = $urandom_range(sb.rows - 1);
			end
			r.occupied = ($urandom_range(99) < 30);
		end else begin
			r.mode = MODE_SEARCH;
			if ($urandom_range(99) < 85) begin
				r.start_x = $urandom_range(sb.cols - 1);
				r.start_y = $urandom_range(sb.rows - 1);
			end
			if ($urandom_range(99) < 85) begin
				r.goal_x = $urandom_range(sb.cols - 1);
				r.goal_y = $urandom_range(sb.rows - 1);
			end
		end
		return r;
	endfunction

	initial begin
		int areas [4][2] = '{'{1, 1}, '{6, 5}, '{8, 6}, '{4, 8}};
		int idles [4] = '{0, 66, 0, 13};
		int stalls [4] = '{0, 0, 66, 13};
		int sx, sy, k;
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		arst_n = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;

		// Directed: small area first, then the largest area
		write_cfg(CFG_WIDTH, 7);
		write_cfg(CFG_HEIGHT, 5);
		send(search_item(2, 2, 0, 2, 2));       // start on goal
		send(search_item(0, 0, 0, 6, 4));       // opposite corners
		send(search_item(3, 1, 15, 3, 4));      // top heading
		send(search_item(1, 1, 4, 63, 31));     // goal out of bounds
		send(occ_item(63, 31, 1));              // cell outside area
		send(occ_item(3, 0, 1));
		send(occ_item(3, 1, 1));
		send(occ_item(3, 2, 1));
		send(search_item(0, 1, 0, 6, 1));       // detour around a wall
		send(search_item(3, 1, 8, 0, 1));       // start on a blocked cell
		send(search_item(6, 1, 12, 60, 1));     // goal out of bounds
		send(occ_item(3, 3, 1));
		send(occ_item(3, 4, 1));
		send(search_item(0, 0, 0, 6, 0));       // wall closes the way
		for (int i = 0; i < 5; i++) send(occ_item(3, i, 0));
		set_area(64, 32);
		for (int i = 0; i < 4; i++) begin
			sx = $urandom_range(1, 62);
			sy = $urandom_range(1, 30);
			k = $urandom_range(15);
			send(occ_item(sx + sb.step_dx(k), sy + sb.step_dy(k), 0));
			send(search_item(sx, sy, k, sx + sb.step_dx(k), sy + sb.step_dy(k)));
		end
		send(search_item(63, 31, 7, 63, 31));

		// Random phases over small areas and all idling patterns
		for (int ph = 0; ph < 4; ph++) begin
			set_area(areas[ph][0], areas[ph][1]);
			idle_pct = idles[ph];
			stall_pct = stalls[ph];
			for (int i = 0; i < 25; i++) send(random_item());
		end
		drain();
		stall_pct = 0;
		repeat (50) @(negedge clk);

		$display("Covered %0d searches and %0d occupancy writes over areas from 1x1 to 64x32,",
			sb.searches, sb.writes);
		$display("with sender gaps and result stalls alone, together and absent.");
		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
